FILE: sv/pidt_pkg.sv
// types, codes and the control store of the process id table sequencer
// depends on nothing; imported by process_id_table
package pidt_pkg;

  localparam int KIND_W   = 2;
  localparam int HANDLE_W = 32;
  localparam int PID_W    = 7;
  localparam int STATUS_W = 2;

  localparam logic [KIND_W-1:0] KIND_GET_PID    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_GET_PARENT = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SET_PARENT = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_INVALID   = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NO_PARENT = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd3;

  typedef enum logic [3:0] {
    S_CHECK,
    S_SCAN,
    S_CMP,
    S_DEC_FOUND,
    S_DEC_EMPTY,
    S_DEC_ROOM,
    S_FULL,
    S_USE_EMPTY,
    S_APPEND,
    S_OP,
    S_INV
  } step_e;

  typedef enum logic [2:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_INVALID,
    COND_SCAN_END,
    COND_FOUND,
    COND_EMPTY,
    COND_ROOM
  } cond_e;

  typedef enum logic [1:0] {
    SEL_NONE,
    SEL_FOUND,
    SEL_EMPTY,
    SEL_USED
  } sel_e;

  typedef enum logic [1:0] {
    RES_NONE,
    RES_OP,
    RES_FULL,
    RES_INV
  } res_e;

  // one control word; on a true condition the step counter loads tgt, else it counts up
  typedef struct packed {
    cond_e cond;
    step_e tgt;
    logic  init;   // set scan index to one, clear match registers
    logic  cmp;    // compare stored handle, advance scan index
    logic  pld;    // load parent from parent store read port
    sel_e  sel;    // slot register source
    logic  alloc;  // write handle into slot, clear its parent
    logic  inc;    // bump used count
    res_e  res;    // emit result and leave
  } ucode_t;

  function automatic ucode_t ucode_rom(step_e step);
    ucode_t w;
    w = '0;
    case (step)
      S_CHECK: begin
        w.cond = COND_INVALID;
        w.tgt  = S_INV;
        w.init = 1'b1;
      end
      S_SCAN: begin
        w.cond = COND_SCAN_END;
        w.tgt  = S_DEC_FOUND;
      end
      S_CMP: begin
        w.cond = COND_ALWAYS;
        w.tgt  = S_SCAN;
        w.cmp  = 1'b1;
      end
      S_DEC_FOUND: begin
        w.cond = COND_FOUND;
        w.tgt  = S_OP;
        w.sel  = SEL_FOUND;
        w.pld  = 1'b1;
      end
      S_DEC_EMPTY: begin
        w.cond = COND_EMPTY;
        w.tgt  = S_USE_EMPTY;
        w.sel  = SEL_EMPTY;
      end
      S_DEC_ROOM: begin
        w.cond = COND_ROOM;
        w.tgt  = S_APPEND;
        w.sel  = SEL_USED;
      end
      S_FULL: begin
        w.res = RES_FULL;
      end
      S_USE_EMPTY: begin
        w.cond  = COND_ALWAYS;
        w.tgt   = S_OP;
        w.alloc = 1'b1;
      end
      S_APPEND: begin
        w.alloc = 1'b1;
        w.inc   = 1'b1;
      end
      S_OP: begin
        w.res = RES_OP;
      end
      S_INV: begin
        w.res = RES_INV;
      end
      default: begin
        w.res = RES_INV;
      end
    endcase
    return w;
  endfunction

endpackage

FILE: sv/pidt_ram.sv
// generic single write port, single read port ram with registered read data
// no dependencies
module pidt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/process_id_table.sv
// process id table: handle to pid map with parent ids, run by a microcoded sequencer
// depends on pidt_pkg and pidt_ram
//
//  channel   signals                                   handshake
//  request   kind_i, proc_handle_i, new_parent_i       start_i high while busy_o low
//  result    pid_o, parent_pid_o, status_o             done_o high for one cycle
//
// with u the used count (reserved slot zero included), the scan spends a read step and a
// compare step on each of slots 1 .. u-1; an invalid request skips the scan. After it the
// sequencer uses the found slot, reuses a free slot, appends a slot or reports the table full.
// reset leaves the table empty with the used count at one; no clearing pass is needed
// since slots at or past the used count are never read before being written.
// the result receiver cannot stall; a new request may start in the done_o cycle.
module process_id_table import pidt_pkg::*; #(
  parameter int SLOTS       = 128,
  parameter int HANDLE_BITS = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  logic [KIND_W-1:0]   kind_i,
  input  logic [HANDLE_W-1:0] proc_handle_i,
  input  logic [PID_W-1:0]    new_parent_i,
  output logic                done_o,
  output logic [PID_W-1:0]    pid_o,
  output logic [PID_W-1:0]    parent_pid_o,
  output logic [STATUS_W-1:0] status_o
);

  localparam int HW = (HANDLE_BITS < HANDLE_W) ? HANDLE_BITS : HANDLE_W;
  localparam int SW = $clog2(SLOTS);
  localparam int UW = $clog2(SLOTS + 1);

  logic                busy_q;
  logic                done_q;
  step_e               upc_q;
  step_e               upc_d;
  logic [KIND_W-1:0]   kind_q;
  logic [HW-1:0]       hdl_q;
  logic [PID_W-1:0]    np_q;
  logic [UW-1:0]       idx_q;
  logic [SW-1:0]       found_q;
  logic [SW-1:0]       empty_q;
  logic [SW-1:0]       slot_q;
  logic [UW-1:0]       used_q;
  logic [PID_W-1:0]    par_q;
  logic [PID_W-1:0]    pid_q;
  logic [PID_W-1:0]    ppid_q;
  logic [STATUS_W-1:0] status_q;

  ucode_t           uc;
  logic             hit;
  logic             invalid;
  logic [HW-1:0]    hdl_rdata;
  logic [PID_W-1:0] par_rdata;
  logic             hdl_we;
  logic             par_we;
  logic [PID_W-1:0] par_wdata;

  assign uc = ucode_rom(upc_q);

  assign invalid = (hdl_q == '0)
                || ((kind_q != KIND_GET_PID) && (kind_q != KIND_GET_PARENT)
                    && (kind_q != KIND_SET_PARENT))
                || ((kind_q == KIND_SET_PARENT) && (np_q == '0));

  always_comb begin
    case (uc.cond)
      COND_NEVER:    hit = 1'b0;
      COND_ALWAYS:   hit = 1'b1;
      COND_INVALID:  hit = invalid;
      COND_SCAN_END: hit = (idx_q >= used_q);
      COND_FOUND:    hit = (found_q != '0);
      COND_EMPTY:    hit = (empty_q != '0);
      COND_ROOM:     hit = (used_q < UW'(SLOTS));
      default:       hit = 1'b0;
    endcase
    upc_d = hit ? uc.tgt : step_e'(upc_q + 4'd1);
  end

  assign hdl_we    = busy_q && uc.alloc;
  assign par_we    = busy_q && (uc.alloc
                  || ((uc.res == RES_OP) && (kind_q == KIND_SET_PARENT)));
  assign par_wdata = uc.alloc ? '0 : np_q;

  pidt_ram #(
    .WIDTH(HW),
    .DEPTH(SLOTS)
  ) u_handle_ram (
    .clk_i  (clk_i),
    .we_i   (hdl_we),
    .waddr_i(slot_q),
    .wdata_i(hdl_q),
    .raddr_i(idx_q[SW-1:0]),
    .rdata_o(hdl_rdata)
  );

  // read port follows the match register, so it is ready by the decide step
  pidt_ram #(
    .WIDTH(PID_W),
    .DEPTH(SLOTS)
  ) u_parent_ram (
    .clk_i  (clk_i),
    .we_i   (par_we),
    .waddr_i(slot_q),
    .wdata_i(par_wdata),
    .raddr_i(found_q),
    .rdata_o(par_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      done_q   <= 1'b0;
      upc_q    <= S_CHECK;
      used_q   <= UW'(1);
      pid_q    <= '0;
      ppid_q   <= '0;
      status_q <= STATUS_OK;
    end else begin
      done_q <= 1'b0;
      if (!busy_q) begin
        if (start_i) begin
          busy_q <= 1'b1;
          upc_q  <= S_CHECK;
          kind_q <= kind_i;
          hdl_q  <= proc_handle_i[HW-1:0];
          np_q   <= new_parent_i;
        end
      end else begin
        upc_q <= upc_d;
        if (uc.init) begin
          idx_q   <= UW'(1);
          found_q <= '0;
          empty_q <= '0;
        end
        if (uc.cmp) begin
          // later slots win, so the highest match or hole is kept
          if (hdl_rdata == hdl_q) begin
            found_q <= idx_q[SW-1:0];
          end else if (hdl_rdata == '0) begin
            empty_q <= idx_q[SW-1:0];
          end
          idx_q <= idx_q + UW'(1);
        end
        case (uc.sel)
          SEL_FOUND: slot_q <= found_q;
          SEL_EMPTY: slot_q <= empty_q;
          SEL_USED:  slot_q <= used_q[SW-1:0];
          default:   ;
        endcase
        if (uc.pld) begin
          par_q <= par_rdata;
        end
        if (uc.alloc) begin
          par_q <= '0;
        end
        if (uc.inc) begin
          used_q <= used_q + UW'(1);
        end
        case (uc.res)
          RES_OP: begin
            busy_q <= 1'b0;
            done_q <= 1'b1;
            if ((kind_q == KIND_GET_PARENT) && (par_q == '0)) begin
              pid_q    <= '0;
              ppid_q   <= '0;
              status_q <= STATUS_NO_PARENT;
            end else begin
              pid_q    <= PID_W'(slot_q);
              ppid_q   <= (kind_q == KIND_GET_PARENT) ? par_q : '0;
              status_q <= STATUS_OK;
            end
          end
          RES_FULL: begin
            busy_q   <= 1'b0;
            done_q   <= 1'b1;
            pid_q    <= '0;
            ppid_q   <= '0;
            status_q <= STATUS_FULL;
          end
          RES_INV: begin
            busy_q   <= 1'b0;
            done_q   <= 1'b1;
            pid_q    <= '0;
            ppid_q   <= '0;
            status_q <= STATUS_INVALID;
          end
          default: ;
        endcase
      end
    end
  end

  assign busy_o       = busy_q;
  assign done_o       = done_q;
  assign pid_o        = pid_q;
  assign parent_pid_o = ppid_q;
  assign status_o     = status_q;

endmodule
